FILE: rtl/lpfb_pkg.sv
package lpfb_pkg;

  // Bytes in a frame header (big-endian payload length).
  localparam int unsigned HDR_BYTES = 4;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_BYTE      = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DROPPED   = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HDR  = 2'd1,
    BK_EVAL = 2'd2,
    BK_READ = 2'd3
  } back_state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [12:0] fill_level;
    status_e     status;
    logic        last;
    logic [7:0]  out_byte;
  } res_t;

endpackage

FILE: rtl/lpfb_front.sv
module lpfb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_cmd_i,
  input  logic [7:0]         in_data_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output lpfb_pkg::item_t    q_item_o
);

  lpfb_pkg::item_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;
  lpfb_pkg::item_t item_in;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // Every code is carried through; the back end answers the unused one.
  always_comb begin
    item_in.cmd  = lpfb_pkg::cmd_e'(in_cmd_i);
    item_in.data = in_data_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: rtl/lpfb_back.sv
module lpfb_back #(
  parameter int unsigned BUF_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_mode_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  lpfb_pkg::item_t    q_item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output lpfb_pkg::res_t     res_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam logic [CW-1:0] FULL   = CW'(BUF_DEPTH);
  localparam logic [CW-1:0] HDR    = CW'(lpfb_pkg::HDR_BYTES);
  localparam logic [31:0]   MAXLEN = 32'(BUF_DEPTH - lpfb_pkg::HDR_BYTES);

  logic [7:0] mem [BUF_DEPTH];

  lpfb_pkg::back_state_e state_q, state_d;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic [CW-1:0]  poff_q, poff_d;
  logic [31:0]    flen_q, flen_d;
  logic           hdr_q, hdr_d;
  logic [2:0]     hcnt_q, hcnt_d;
  logic           pend_last_q, pend_last_d;
  logic           res_valid_q, res_valid_d;
  lpfb_pkg::res_t res_q, res_d;
  logic [7:0]     rdata_q;

  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           out_free, pop;
  logic           is_full, too_big, frame_ready, last_byte;
  logic [CW-1:0]  flen_c, drop_n;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h,
                                             input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(ofs);
    if (sum >= (CW+1)'(BUF_DEPTH)) begin
      sum = sum - (CW+1)'(BUF_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign out_free    = !res_valid_q || res_ready_i;
  assign q_ready_o   = (state_q == lpfb_pkg::BK_IDLE) && out_free;
  assign pop         = q_valid_i && q_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign is_full     = (fill_q == FULL);
  assign too_big     = (flen_q > MAXLEN);
  // Only meaningful once too_big is false, where the length fits a fill count.
  assign flen_c      = flen_q[CW-1:0];
  assign drop_n      = flen_c + HDR;
  assign frame_ready = ({1'b0, fill_q} >= ((CW+1)'(flen_c) + (CW+1)'(HDR)));
  assign last_byte   = (((CW+1)'(poff_q) + (CW+1)'(1)) >= (CW+1)'(flen_c));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpfb_pkg::BK_IDLE: begin
        if (pop && q_item_i.cmd == lpfb_pkg::CMD_PULL) begin
          if (!frame_mode_i) begin
            if (fill_q != '0) state_d = lpfb_pkg::BK_READ;
          end else if (hdr_q) begin
            state_d = lpfb_pkg::BK_EVAL;
          end else if (fill_q >= HDR) begin
            state_d = lpfb_pkg::BK_HDR;
          end
        end
      end
      lpfb_pkg::BK_HDR: begin
        if (hcnt_q == 3'd4) state_d = lpfb_pkg::BK_EVAL;
      end
      lpfb_pkg::BK_EVAL: begin
        if (out_free) begin
          if (!too_big && flen_q != '0 && frame_ready) begin
            state_d = lpfb_pkg::BK_READ;
          end else begin
            state_d = lpfb_pkg::BK_IDLE;
          end
        end
      end
      lpfb_pkg::BK_READ: begin
        if (out_free) state_d = lpfb_pkg::BK_IDLE;
      end
      default: state_d = lpfb_pkg::BK_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    poff_d      = poff_q;
    flen_d      = flen_q;
    hdr_d       = hdr_q;
    hcnt_d      = hcnt_q;
    pend_last_d = pend_last_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    wr_addr     = ring_pos(head_q, fill_q);

    unique case (state_q)
      lpfb_pkg::BK_IDLE: begin
        if (pop) begin
          res_d.out_byte = 8'd0;
          res_d.last     = 1'b0;
          res_d.status   = lpfb_pkg::ST_NOT_READY;
          res_valid_d    = 1'b1;
          unique case (q_item_i.cmd)
            lpfb_pkg::CMD_PUSH: begin
              if (is_full) begin
                res_d.status = lpfb_pkg::ST_DROPPED;
              end else begin
                wr_en        = 1'b1;
                fill_d       = fill_q + CW'(1);
                res_d.status = lpfb_pkg::ST_PUSHED;
              end
            end
            lpfb_pkg::CMD_CLEAR: begin
              head_d       = '0;
              fill_d       = '0;
              poff_d       = '0;
              flen_d       = '0;
              hdr_d        = 1'b0;
              res_d.status = lpfb_pkg::ST_CLEARED;
            end
            lpfb_pkg::CMD_PULL: begin
              if (!frame_mode_i) begin
                hdr_d  = 1'b0;
                poff_d = '0;
                if (fill_q != '0) begin
                  rd_en       = 1'b1;
                  head_d      = ring_pos(head_q, CW'(1));
                  fill_d      = fill_q - CW'(1);
                  pend_last_d = (fill_q == CW'(1));
                  res_valid_d = 1'b0;
                end
              end else if (hdr_q || fill_q >= HDR) begin
                // The result comes out of the evaluation step.
                res_valid_d = 1'b0;
                hcnt_d      = 3'd0;
              end
            end
            lpfb_pkg::CMD_NONE: begin
            end
            default: begin
            end
          endcase
          res_d.fill_level = 13'(fill_d);
        end
      end
      lpfb_pkg::BK_HDR: begin
        // One header byte read per cycle; each lands in rdata_q in the next cycle.
        rd_en   = (hcnt_q != 3'd4);
        rd_addr = ring_pos(head_q, CW'(hcnt_q[1:0]));
        hcnt_d  = hcnt_q + 3'd1;
        if (hcnt_q != 3'd0) flen_d = {flen_q[23:0], rdata_q};
        if (hcnt_q == 3'd4) begin
          hdr_d  = 1'b1;
          poff_d = '0;
        end
      end
      lpfb_pkg::BK_EVAL: begin
        if (out_free) begin
          res_d.out_byte = 8'd0;
          res_d.last     = 1'b0;
          res_d.status   = lpfb_pkg::ST_NOT_READY;
          res_valid_d    = 1'b1;
          if (too_big) begin
            res_d.status = lpfb_pkg::ST_TOO_LARGE;
          end else if (flen_q == '0) begin
            head_d       = ring_pos(head_q, HDR);
            fill_d       = fill_q - HDR;
            hdr_d        = 1'b0;
            res_d.last   = 1'b1;
            res_d.status = lpfb_pkg::ST_EMPTY;
          end else if (frame_ready) begin
            rd_en       = 1'b1;
            rd_addr     = ring_pos(head_q, poff_q + HDR);
            res_valid_d = 1'b0;
            poff_d      = poff_q + CW'(1);
            pend_last_d = last_byte;
            if (last_byte) begin
              head_d = ring_pos(head_q, drop_n);
              fill_d = fill_q - drop_n;
              hdr_d  = 1'b0;
              poff_d = '0;
            end
          end
          res_d.fill_level = 13'(fill_d);
        end
      end
      lpfb_pkg::BK_READ: begin
        if (out_free) begin
          res_valid_d      = 1'b1;
          res_d.out_byte   = rdata_q;
          res_d.last       = pend_last_q;
          res_d.status     = lpfb_pkg::ST_BYTE;
          res_d.fill_level = 13'(fill_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpfb_pkg::BK_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      poff_q      <= '0;
      flen_q      <= '0;
      hdr_q       <= 1'b0;
      hcnt_q      <= 3'd0;
      pend_last_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      poff_q      <= poff_d;
      flen_q      <= flen_d;
      hdr_q       <= hdr_d;
      hcnt_q      <= hcnt_d;
      pend_last_q <= pend_last_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= q_item_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL)
    else $error("fill count exceeds capacity");

  a_offset_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q && flen_q != '0) |-> (32'(poff_q) < flen_q))
    else $error("payload offset past end of frame");

  a_hdr_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpfb_pkg::BK_HDR) |-> (fill_q >= HDR))
    else $error("header read with fewer than four bytes held");

  a_read_has_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpfb_pkg::BK_READ && out_free) |=> res_valid_q)
    else $error("byte read lost its result");
`endif

endmodule

FILE: rtl/length_prefixed_frame_buffer.sv
// A result is valid on the master side after its transaction is accepted, registered from the
// idle step for push, clear, unused commands and pulls that cannot start; a raw pull reads its
// byte and then returns it; a framed pull whose header is held passes through evaluation and,
// if the frame is ready, a byte read; a header read comes first when the header is not held.
// Pushes: one item per cycle while results are accepted; while a pull runs, items only fill the two-entry input queue.
// Reset (asynchronous, active low) empties the store and selects unframed mode.
module length_prefixed_frame_buffer #(
  parameter int unsigned BUF_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [10:8] status, [23:11] fill_level
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic            frame_mode_q, frame_mode_d;
  logic            q_valid, q_ready;
  lpfb_pkg::item_t q_item;
  lpfb_pkg::res_t  res;

  assign cfg_ready_o  = 1'b1;
  assign frame_mode_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : frame_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q <= 1'b0;
    end else begin
      frame_mode_q <= frame_mode_d;
    end
  end

  lpfb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  lpfb_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_mode_i (frame_mode_q),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_item_i     (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {res.fill_level, res.status, res.out_byte};
  assign m_axis_tlast = res.last;

endmodule
